[rtl/tor_pkg.sv]
`timescale 1ns / 1ps

package tor_pkg;

    // default number of session slots
    localparam int SLOTS_DEFAULT = 4;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;

    // text bytes
    localparam logic [7:0] B_LF        = 8'h0A;
    localparam logic [7:0] B_CR        = 8'h0D;
    localparam logic [7:0] B_PRINT_LO  = 8'h20;
    localparam logic [7:0] B_DEL       = 8'h7F;

    // line limit after reset
    localparam logic [9:0] MAX_LINE_RESET = 10'd512;

    // input modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_OPEN = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EOL   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [1:0] slot;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] out_slot;
        logic       last;
    } out_item_t;

endpackage

[rtl/telnet_option_refuser.sv]
`timescale 1ns / 1ps
// the first result of an input transaction passes the input register, then the result register
// one input item per cycle while the result buffer has room; an option reply is three bytes
// the per-slot parser state, held in flip-flops, is read and written in the same cycle
// reset (rst_n low, asynchronous) puts every slot in text state with zero line count
// and sets the line limit to 512; no clearing pass is needed
module telnet_option_refuser #(
    parameter int SLOTS = tor_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tor_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tor_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [9:0]          cfg_data
);
    import tor_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_TEXT    = 3'd0,
        ST_IAC     = 3'd1,
        ST_OPT     = 3'd2,
        ST_SUB     = 3'd3,
        ST_SUB_IAC = 3'd4
    } parse_state_t;

    typedef struct packed {
        logic [1:0]            count;
        out_item_t [2:0]       items;
    } burst_t;

    // configuration register
    logic [9:0] max_line_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= MAX_LINE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_line_reg <= cfg_data;
        end
    end

    // input register
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      fire;
    logic      can_load;
    logic      pop;

    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    // per-slot state
    parse_state_t parse_state_reg [SLOTS];
    logic [7:0]   pending_verb_reg [SLOTS];
    logic [9:0]   line_count_reg [SLOTS];

    logic [SLOT_W+1:0]  slot_wide;
    logic [SLOT_W-1:0]  slot_idx;
    logic               slot_ok;
    parse_state_t       cur_state;
    logic [7:0]         cur_verb;
    logic [9:0]         cur_count;
    parse_state_t       state_next;
    logic [7:0]         verb_next;
    logic [9:0]         count_next;
    logic [7:0]         b;
    logic [7:0]         reply;
    burst_t             burst;

    assign slot_wide = {{SLOT_W{1'b0}}, in_item_reg.slot};
    assign slot_idx  = slot_wide[SLOT_W-1:0];
    assign slot_ok   = (32'(in_item_reg.slot) < SLOTS);
    assign cur_state = parse_state_reg[slot_idx];
    assign cur_verb  = pending_verb_reg[slot_idx];
    assign cur_count = line_count_reg[slot_idx];
    assign b         = in_item_reg.data_byte;

    // parser step for the slot held in the input register
    always_comb
    begin
        state_next = cur_state;
        verb_next  = cur_verb;
        count_next = cur_count;
        reply      = B_WONT;
        burst      = '0;
        if (!slot_ok)
        begin
            burst.count = 2'd0;
        end
        else if (in_item_reg.mode == MODE_OPEN)
        begin
            state_next = ST_TEXT;
            verb_next  = 8'd0;
            count_next = 10'd0;
        end
        else
        begin
            unique case (cur_state)
                ST_IAC:
                begin
                    if (b == B_SB)
                    begin
                        state_next = ST_SUB;
                    end
                    else if (b >= B_WILL && b <= B_DONT)
                    begin
                        verb_next  = b;
                        state_next = ST_OPT;
                    end
                    else
                    begin
                        state_next = ST_TEXT;
                    end
                end
                ST_OPT:
                begin
                    state_next = ST_TEXT;
                    reply = (cur_verb == B_DO) ? B_WONT : B_DONT;
                    if (cur_verb == B_DO || cur_verb == B_WILL)
                    begin
                        burst.count    = 2'd3;
                        burst.items[0] = '{kind: KIND_REPLY, out_byte: B_IAC,
                                           out_slot: in_item_reg.slot, last: 1'b0};
                        burst.items[1] = '{kind: KIND_REPLY, out_byte: reply,
                                           out_slot: in_item_reg.slot, last: 1'b0};
                        burst.items[2] = '{kind: KIND_REPLY, out_byte: b,
                                           out_slot: in_item_reg.slot, last: 1'b1};
                    end
                end
                ST_SUB:
                begin
                    if (b == B_IAC)
                    begin
                        state_next = ST_SUB_IAC;
                    end
                end
                ST_SUB_IAC:
                begin
                    state_next = (b == B_SE) ? ST_TEXT : ST_SUB;
                end
                default:
                begin
                    state_next = ST_TEXT;
                    if (b == B_IAC)
                    begin
                        state_next = ST_IAC;
                    end
                    else if (b == B_LF || b == B_CR)
                    begin
                        if (cur_count != 10'd0)
                        begin
                            burst.count    = 2'd1;
                            burst.items[0] = '{kind: KIND_EOL, out_byte: 8'd0,
                                               out_slot: in_item_reg.slot, last: 1'b1};
                            count_next     = 10'd0;
                        end
                    end
                    else if (b >= B_PRINT_LO && b < B_DEL && cur_count < max_line_reg)
                    begin
                        burst.count    = 2'd1;
                        burst.items[0] = '{kind: KIND_CHAR, out_byte: b,
                                           out_slot: in_item_reg.slot, last: 1'b1};
                        count_next     = cur_count + 10'd1;
                    end
                end
            endcase
        end
    end

    assign fire = in_valid_reg && (burst.count == 2'd0 || can_load);

    // state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                parse_state_reg[i]  <= ST_TEXT;
                pending_verb_reg[i] <= 8'd0;
                line_count_reg[i]   <= 10'd0;
            end
        end
        else if (fire && slot_ok)
        begin
            parse_state_reg[slot_idx]  <= state_next;
            pending_verb_reg[slot_idx] <= verb_next;
            line_count_reg[slot_idx]   <= count_next;
        end
    end

    // result buffer, head at entry zero
    out_item_t  buf_reg [3];
    logic [1:0] buf_count_reg;
    logic       load;

    assign out_valid = (buf_count_reg != 2'd0);
    assign out_data  = buf_reg[0];
    assign pop       = out_valid && !out_stall;
    assign can_load  = (buf_count_reg == 2'd0) || (buf_count_reg == 2'd1 && pop);
    assign load      = fire && (burst.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_count_reg <= 2'd0;
        end
        else if (load)
        begin
            buf_count_reg <= burst.count;
        end
        else if (pop)
        begin
            buf_count_reg <= buf_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg[0] <= burst.items[0];
            buf_reg[1] <= burst.items[1];
            buf_reg[2] <= burst.items[2];
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    // checks
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (buf_count_reg == 2'd1)))
        else $error("last flag does not match remaining results");

    a_burst_head_iac: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_count_reg == 2'd3) |-> (out_data.kind == KIND_REPLY && out_data.out_byte == B_IAC))
        else $error("reply burst does not start with IAC");

    a_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_EOL) |-> (out_data.out_byte == 8'd0))
        else $error("end of line carries a non-zero byte");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded results not presented");

endmodule

[test/telnet_option_refuser_tb.sv]
`timescale 1ns / 1ps

module telnet_option_refuser_tb;

    import tor_pkg::*;

    // parser states of one session slot
    typedef enum logic [2:0] {
        PS_TEXT    = 3'd0,
        PS_IAC     = 3'd1,
        PS_OPTION  = 3'd2,
        PS_SUB     = 3'd3,
        PS_SUB_IAC = 3'd4
    } parse_state_t;

    localparam int NUM_SLOTS    = SLOTS_DEFAULT;
    localparam int SETTLE_TICKS = 6;
    localparam int IDLE_PERCENT = 18;

    // tracks per-slot parser state, predicts the filtered stream and checks it
    class refusal_board;
        parse_state_t   pstate [NUM_SLOTS];
        logic [7:0]     verb [NUM_SLOTS];
        logic [9:0]     line_len [NUM_SLOTS];
        logic [9:0]     line_limit;
        out_item_t      expected [$];
        int             errors;
        int             results_seen;
        int             chars_seen;
        int             eols_seen;
        int             replies_seen;

        function new();
            line_limit = MAX_LINE_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pstate[i]   = PS_TEXT;
                verb[i]     = '0;
                line_len[i] = '0;
            end
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] b, logic [1:0] slot);
            out_item_t r;
            r.kind     = kind;
            r.out_byte = b;
            r.out_slot = slot;
            r.last     = 1'b0;
            expected.push_back(r);
        endfunction

        // works out the results one accepted transaction causes
        function void note_input(in_item_t it);
            int         s;
            int         before_len;
            logic [7:0] b;
            logic [7:0] answer;
            s          = int'(it.slot);
            b          = it.data_byte;
            before_len = expected.size();
            answer     = '0;
            if (s >= NUM_SLOTS)
                return;
            // new connection clears the slot
            if (it.mode == MODE_OPEN)
            begin
                pstate[s]   = PS_TEXT;
                verb[s]     = '0;
                line_len[s] = '0;
                return;
            end
            case (pstate[s])
                PS_IAC:
                begin
                    if (b == B_SB)
                        pstate[s] = PS_SUB;
                    else if (b >= B_WILL && b <= B_DONT)
                    begin
                        verb[s]   = b;
                        pstate[s] = PS_OPTION;
                    end
                    else
                        pstate[s] = PS_TEXT;
                end
                PS_OPTION:
                begin
                    // refuse every option, stay silent on wont and dont
                    if (verb[s] == B_DO)
                        answer = B_WONT;
                    else if (verb[s] == B_WILL)
                        answer = B_DONT;
                    pstate[s] = PS_TEXT;
                    if (answer != 8'd0)
                    begin
                        push_result(KIND_REPLY, B_IAC, it.slot);
                        push_result(KIND_REPLY, answer, it.slot);
                        push_result(KIND_REPLY, b, it.slot);
                    end
                end
                PS_SUB:
                begin
                    if (b == B_IAC)
                        pstate[s] = PS_SUB_IAC;
                end
                PS_SUB_IAC:
                    pstate[s] = (b == B_SE) ? PS_TEXT : PS_SUB;
                default:
                begin
                    pstate[s] = PS_TEXT;
                    if (b == B_IAC)
                        pstate[s] = PS_IAC;
                    else if (b == B_LF || b == B_CR)
                    begin
                        if (line_len[s] != 10'd0)
                        begin
                            push_result(KIND_EOL, 8'd0, it.slot);
                            line_len[s] = '0;
                        end
                    end
                    else if (b >= B_PRINT_LO && b < B_DEL && line_len[s] < line_limit)
                    begin
                        push_result(KIND_CHAR, b, it.slot);
                        line_len[s] = line_len[s] + 10'd1;
                    end
                end
            endcase
            if (expected.size() > before_len)
                expected[expected.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, out_item_t want, out_item_t got);
            errors++;
            if (errors <= 10)
            begin
                $write("%0t: %s: expected kind %0d byte %02h slot %0d last %0d, ",
                       $realtime, what, want.kind, want.out_byte, want.out_slot, want.last);
                $display("got kind %0d byte %02h slot %0d last %0d",
                         got.kind, got.out_byte, got.out_slot, got.last);
            end
        endfunction

        // compares one accepted result with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (expected.size() == 0)
            begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = expected.pop_front();
            if (want.kind !== got.kind || want.out_byte !== got.out_byte ||
                want.out_slot !== got.out_slot || want.last !== got.last)
                report("result mismatch", want, got);
            else if (got.kind == KIND_CHAR)
                chars_seen++;
            else if (got.kind == KIND_EOL)
                eols_seen++;
            else
                replies_seen++;
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data  = '0;

    refusal_board board = new();
    bit           steady = 1'b0;
    int           items_sent;
    int           limits_used;

    telnet_option_refuser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);

    // result monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    // one input transaction, with an occasional gap afterwards
    task automatic send_item(input logic mode, input logic [1:0] slot, input logic [7:0] b);
        in_item_t it;
        it.mode      = mode;
        it.slot      = slot;
        it.data_byte = b;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(it);
        items_sent++;
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // hold the sender until every expected result has come and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_line_limit(input logic [9:0] limit);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.line_limit = limit;
        limits_used++;
    endtask

    // one mostly well-formed telnet fragment on a random slot
    task automatic send_fragment();
        logic [1:0] s;
        int         pick;
        int         n;
        s    = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // a run of printable text, usually ended by cr or lf
            n = $urandom_range(1, 6);
            repeat (n) send_item(MODE_BYTE, s, 8'($urandom_range(B_PRINT_LO, B_DEL - 1)));
            if ($urandom_range(0, 9) < 7)
                send_item(MODE_BYTE, s, $urandom_range(0, 1) ? B_CR : B_LF);
        end
        else if (pick < 60)
        begin
            // option negotiation with any verb and option
            send_item(MODE_BYTE, s, B_IAC);
            send_item(MODE_BYTE, s, 8'(B_WILL + $urandom_range(0, 3)));
            send_item(MODE_BYTE, s, 8'($urandom_range(0, 255)));
        end
        else if (pick < 72)
        begin
            // subnegotiation, sometimes with a stray iac inside
            send_item(MODE_BYTE, s, B_IAC);
            send_item(MODE_BYTE, s, B_SB);
            repeat ($urandom_range(0, 3)) send_item(MODE_BYTE, s, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
            begin
                send_item(MODE_BYTE, s, B_IAC);
                send_item(MODE_BYTE, s, 8'($urandom_range(0, 255)));
            end
            send_item(MODE_BYTE, s, B_IAC);
            send_item(MODE_BYTE, s, B_SE);
        end
        else if (pick < 80)
        begin
            // escaped iac or another two-byte command
            send_item(MODE_BYTE, s, B_IAC);
            send_item(MODE_BYTE, s, $urandom_range(0, 1) ? B_IAC : 8'($urandom_range(0, 255)));
        end
        else if (pick < 88)
            send_item(MODE_OPEN, s, 8'($urandom_range(0, 255)));
        else
            send_item(MODE_BYTE, s, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_fragment();
    endtask

    // watchdog
    initial
    begin
        #2_000_000;
        $display("telnet_option_refuser_tb failed");
        $finish;
    end

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: printable bounds, dropped bytes, line ends
        send_item(MODE_BYTE, 2'd0, 8'h41);
        send_item(MODE_BYTE, 2'd0, B_PRINT_LO);
        send_item(MODE_BYTE, 2'd0, 8'h7E);
        send_item(MODE_BYTE, 2'd0, B_DEL);
        send_item(MODE_BYTE, 2'd0, 8'h00);
        send_item(MODE_BYTE, 2'd0, B_CR);
        send_item(MODE_BYTE, 2'd0, B_LF);
        // escaped iac and an unrelated command
        send_item(MODE_BYTE, 2'd0, B_IAC);
        send_item(MODE_BYTE, 2'd0, B_IAC);
        send_item(MODE_BYTE, 2'd0, B_IAC);
        send_item(MODE_BYTE, 2'd0, 8'hF1);
        // every negotiation verb
        send_item(MODE_BYTE, 2'd0, B_IAC);
        send_item(MODE_BYTE, 2'd0, B_DO);
        send_item(MODE_BYTE, 2'd0, 8'h18);
        send_item(MODE_BYTE, 2'd3, B_IAC);
        send_item(MODE_BYTE, 2'd3, B_WILL);
        send_item(MODE_BYTE, 2'd3, 8'h00);
        send_item(MODE_BYTE, 2'd1, B_IAC);
        send_item(MODE_BYTE, 2'd1, B_WONT);
        send_item(MODE_BYTE, 2'd1, 8'h05);
        send_item(MODE_BYTE, 2'd2, B_IAC);
        send_item(MODE_BYTE, 2'd2, B_DONT);
        send_item(MODE_BYTE, 2'd2, 8'hFF);
        // subnegotiation with iac followed by a non-se byte
        send_item(MODE_BYTE, 2'd2, B_IAC);
        send_item(MODE_BYTE, 2'd2, B_SB);
        send_item(MODE_BYTE, 2'd2, B_IAC);
        send_item(MODE_BYTE, 2'd2, 8'h01);
        send_item(MODE_BYTE, 2'd2, B_IAC);
        send_item(MODE_BYTE, 2'd2, B_SE);
        // reset of a slot left waiting for a command byte
        send_item(MODE_BYTE, 2'd1, B_IAC);
        send_item(MODE_OPEN, 2'd1, 8'hFF);
        send_item(MODE_BYTE, 2'd1, 8'h7A);

        // random traffic under several line limits
        set_line_limit(10'd3);
        random_phase(50);
        set_line_limit(10'd0);
        random_phase(50);
        set_line_limit(10'd1023);
        steady = 1'b1;
        random_phase(50);
        steady = 1'b0;
        set_line_limit(10'($urandom_range(1, 12)));
        random_phase(50);

        drain();
        if (board.expected.size() != 0)
        begin
            $display("%0d expected results never arrived", board.expected.size());
            board.errors += board.expected.size();
        end
        $display("%0d input transactions under %0d line limits; %0d results checked",
                 items_sent, limits_used + 1, board.results_seen);
        $display("%0d line characters, %0d line ends, %0d reply bytes matched",
                 board.chars_seen, board.eols_seen, board.replies_seen);
        if (board.errors == 0)
            $display("telnet_option_refuser_tb passed");
        else
            $display("telnet_option_refuser_tb failed");
        $finish;
    end

endmodule
